[rtl/core/assert_macros.svh]
// Assertion macros shared by the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CHK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, cond, res, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) else $error(msg);
`else
`define ASSERT_CHK(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, cond, res, msg)
`endif
`endif

[rtl/core/mf5_pkg.sv]
// Package: types and constants for the 5x5 median filter.
package mf5_pkg;
    localparam int MaxWidth   = 256;
    localparam int ColW       = $clog2(MaxWidth);
    localparam int Win        = 5;
    localparam int WinArea    = 25;
    localparam int MedianRank = 12;
    localparam int Lines      = 4;
    localparam int QDepth     = 4;
    localparam logic [8:0] WidthReset = 9'd256;
    localparam logic [0:0] RegImageWidth = 1'b0;

    typedef logic [7:0] pix_t;
    typedef pix_t [Win-1:0] col_t;

    // column entry passed from front to back
    typedef struct packed {
        col_t col;
        logic valid;
        logic interior;
    } col_item_t;

    typedef struct packed {
        pix_t result;
        logic valid;
    } res_t;
endpackage

[rtl/core/mf5_front.sv]
// Front end: position counters, line stores and column assembly.
module mf5_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [8:0]        image_width,
    input  logic              in_take,
    input  logic [7:0]        pixel,
    input  logic              frame_start,
    output logic              item_valid,
    output mf5_pkg::col_item_t item
);
    import mf5_pkg::*;

    logic [ColW-1:0] column_reg;
    logic [ColW-1:0] column_next;
    logic [2:0]      row_reg;
    logic [2:0]      row_next;
    logic [8*Lines-1:0] mem [MaxWidth];
    logic [8*Lines-1:0] rd_data;
    logic [8:0]      w_eff;
    logic [ColW-1:0] c_use;
    logic [2:0]      r_use;
    logic            valid_reg;
    logic            interior_reg;
    logic [7:0]      px_reg;
    logic            take_reg;

    always_comb
    begin
        if (image_width < 9'd5)
            w_eff = 9'd5;
        else if (image_width > 9'(MaxWidth))
            w_eff = 9'(MaxWidth);
        else
            w_eff = image_width;
        c_use = frame_start ? '0 : column_reg;
        r_use = frame_start ? '0 : row_reg;
        if ({1'b0, c_use} + 9'd1 >= w_eff)
        begin
            column_next = '0;
            row_next    = (r_use < 3'd4) ? r_use + 3'd1 : r_use;
        end
        else
        begin
            column_next = c_use + 1'b1;
            row_next    = r_use;
        end
    end

    // read-before-write line store; write in stage 2 at the registered column
    logic [ColW-1:0] wa_reg;
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            // frame start right after a column-0 pixel hits the column still being written
            if (take_reg && wa_reg == c_use)
                rd_data <= {rd_data[8*(Lines-1)-1:0], px_reg};
            else
                rd_data <= mem[c_use];
            wa_reg  <= c_use;
            px_reg  <= pixel;
        end
        if (take_reg)
            mem[wa_reg] <= {rd_data[8*(Lines-1)-1:0], px_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg   <= '0;
            row_reg      <= '0;
            take_reg     <= 1'b0;
            valid_reg    <= 1'b0;
            interior_reg <= 1'b0;
        end
        else
        begin
            take_reg <= in_take;
            if (in_take)
            begin
                column_reg   <= column_next;
                row_reg      <= row_next;
                valid_reg    <= (r_use >= 3'd2) && (c_use >= ColW'(2));
                interior_reg <= (r_use >= 3'd4) && (c_use >= ColW'(4));
            end
        end
    end

    // col[0] is the oldest line, col[Win-1] the current pixel
    assign item_valid = take_reg;
    assign item       = {px_reg, rd_data[7:0], rd_data[15:8], rd_data[23:16],
                         rd_data[31:24], valid_reg, interior_reg};
endmodule

[rtl/core/mf5_fifo.sv]
// Short queue between the front and back ends.
module mf5_fifo
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr,
    input  mf5_pkg::col_item_t wdata,
    input  logic               rd,
    output logic               not_empty,
    output mf5_pkg::col_item_t rdata,
    output logic [2:0]         count
);
    import mf5_pkg::*;

    col_item_t q_reg [QDepth];
    logic [1:0] wp_reg;
    logic [1:0] rp_reg;
    logic [2:0] cnt_reg;

    always_ff @(posedge clk)
    begin
        if (wr)
            q_reg[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + 1'b1;
            if (rd)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + {2'b0, wr} - {2'b0, rd};
        end
    end

    assign not_empty = (cnt_reg != 3'd0);
    assign rdata     = q_reg[rp_reg];
    assign count     = cnt_reg;

    `include "assert_macros.svh"
    `ASSERT_CHK(a_no_overflow, clk, rst_n, !(wr && !rd && cnt_reg == 3'(QDepth)), "fifo overflow")
    `ASSERT_CHK(a_no_underflow, clk, rst_n, !(rd && cnt_reg == 3'd0), "fifo underflow")
    `ASSERT_NEXT(a_cnt_up, clk, rst_n, wr && !rd, cnt_reg == $past(cnt_reg) + 3'd1, "count")
endmodule

[rtl/core/mf5_back.sv]
// Back end: 5x5 window and pipelined rank-12 selection by pairwise counts.
module mf5_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  mf5_pkg::col_item_t item,
    output logic               busy,
    output logic               res_valid,
    output mf5_pkg::res_t      res
);
    import mf5_pkg::*;

    pix_t win_reg [Win][Win];
    logic v1_reg, v2_reg, v3_reg;
    logic ok1_reg, in1_reg, ok2_reg, in2_reg;
    pix_t s1_reg [WinArea];
    logic [WinArea-1:0] lt_reg [WinArea];
    pix_t s2_reg [WinArea];
    logic [WinArea-1:0] hit_reg;
    pix_t med;
    logic [4:0] rank [WinArea];
    logic [WinArea-1:0] hit;
    logic win_v_reg, win_ok_reg, win_in_reg;

    // stage 0: window shift (row 0 is oldest line)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < Win; r++)
                for (int c = 0; c < Win; c++)
                    win_reg[r][c] <= '0;
            win_v_reg <= 1'b0;
        end
        else
        begin
            win_v_reg <= adv;
            if (adv)
            begin
                for (int r = 0; r < Win; r++)
                begin
                    for (int c = 0; c < Win-1; c++)
                        win_reg[r][c] <= win_reg[r][c+1];
                    win_reg[r][Win-1] <= item.col[r];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            win_ok_reg <= item.valid;
            win_in_reg <= item.interior;
        end
    end

    // stage 1: pairwise compares, stable ranking (ties broken by index)
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < WinArea; i++)
        begin
            s1_reg[i] <= win_reg[i/Win][i%Win];
            for (int j = 0; j < WinArea; j++)
                lt_reg[i][j] <= (j < i) ? (win_reg[j/Win][j%Win] <= win_reg[i/Win][i%Win])
                                        : (win_reg[j/Win][j%Win] <  win_reg[i/Win][i%Win]);
        end
        ok1_reg <= win_ok_reg;
        in1_reg <= win_in_reg;
    end

    // stage 2: count, select one-hot of rank 12
    always_comb
    begin
        for (int i = 0; i < WinArea; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < WinArea; j++)
                rank[i] = rank[i] + {4'b0, lt_reg[i][j]};
            hit[i] = (rank[i] == 5'(MedianRank));
        end
    end

    always_ff @(posedge clk)
    begin
        s2_reg  <= s1_reg;
        hit_reg <= hit;
        ok2_reg <= ok1_reg;
        in2_reg <= in1_reg;
    end

    always_comb
    begin
        med = '0;
        for (int i = 0; i < WinArea; i++)
            med = med | (hit_reg[i] ? s2_reg[i] : 8'd0);
    end

    always_ff @(posedge clk)
    begin
        res.result <= in2_reg ? med : 8'd0;
        res.valid  <= ok2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= win_v_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign res_valid = v3_reg;
    assign busy      = win_v_reg | v1_reg | v2_reg;

    `include "assert_macros.svh"
    // border windows may hold line store entries not yet written
    `ASSERT_CHK(a_onehot, clk, rst_n, !(v2_reg && in2_reg) || $onehot(hit_reg), "rank select not onehot")
endmodule

[rtl/core/median_filter_5x5.sv]
// Throughput: one pixel per clock unless the output stalls; the line store is a single-port
// read plus a delayed write, and the rank pipeline takes a new window every unstalled cycle.
// Output stalls back up through an 8-entry output queue and a 4-entry column queue.
// Reset (rst_n, async, active low) clears counters, window and queues; width reads 256.
// Line store contents are left unknown by reset.
module median_filter_5x5
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel
    input  logic        s_tuser,   // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_pixel
    output logic        m_tuser    // [0] out_valid
);
    import mf5_pkg::*;

    localparam int OQ = 8;

    logic [8:0] width_reg;
    logic       in_take;
    logic       f_valid;
    col_item_t  f_item;
    logic       q_ne;
    col_item_t  q_item;
    logic [2:0] q_cnt;
    logic       adv;
    logic       b_busy;
    logic       r_valid;
    res_t       r_res;
    res_t       oq_reg [OQ];
    logic [2:0] owp_reg, orp_reg;
    logic [3:0] ocnt_reg;
    logic [3:0] inflight;
    logic       out_take;

    assign pready = 1'b1;
    assign prdata = {23'd0, width_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            width_reg <= WidthReset;
        else if (psel && penable && pwrite && paddr == RegImageWidth)
            width_reg <= pwdata[8:0];
    end

    // front may take when the column queue can absorb one more, counting in-flight
    assign s_tready = ({1'b0, q_cnt} + {3'b0, f_valid}) < 4'(QDepth - 1);
    assign in_take  = s_tvalid && s_tready;

    mf5_front u_front (
        .clk, .rst_n, .image_width(width_reg), .in_take,
        .pixel(s_tdata), .frame_start(s_tuser),
        .item_valid(f_valid), .item(f_item)
    );

    // back stage advances when output queue has room for everything in flight
    assign inflight = ocnt_reg + {3'b0, b_busy} + 4'd3;
    assign adv      = q_ne && (inflight < 4'(OQ));

    mf5_fifo u_fifo (
        .clk, .rst_n, .wr(f_valid), .wdata(f_item), .rd(adv),
        .not_empty(q_ne), .rdata(q_item), .count(q_cnt)
    );

    mf5_back u_back (
        .clk, .rst_n, .adv, .item(q_item), .busy(b_busy),
        .res_valid(r_valid), .res(r_res)
    );

    assign out_take = m_tvalid && m_tready;
    assign m_tvalid = ocnt_reg != 4'd0;
    assign m_tdata  = oq_reg[orp_reg].result;
    assign m_tuser  = oq_reg[orp_reg].valid;

    always_ff @(posedge clk)
    begin
        if (r_valid)
            oq_reg[owp_reg] <= r_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owp_reg  <= '0;
            orp_reg  <= '0;
            ocnt_reg <= '0;
        end
        else
        begin
            if (r_valid)
                owp_reg <= owp_reg + 1'b1;
            if (out_take)
                orp_reg <= orp_reg + 1'b1;
            ocnt_reg <= ocnt_reg + {3'b0, r_valid} - {3'b0, out_take};
        end
    end

    `include "assert_macros.svh"
    `ASSERT_CHK(a_oq_ovf, clk, rst_n, !(r_valid && !out_take && ocnt_reg == 4'(OQ)), "out overflow")
    `ASSERT_NEXT(a_stall_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid, "valid dropped")
endmodule
